[design/dcd_pkg.sv]
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared widths, codes and defaults of the dependency-count task dispatcher.
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int LIMIT_MAX     = 16;

    localparam int CMD_W     = 2;
    localparam int TASK_W    = 4;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_EDGE     = 2'd0,
        CMD_START    = 2'd1,
        CMD_COMPLETE = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DISPATCH = 2'd0,
        STAT_NONE     = 2'd1,
        STAT_DONE     = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT = 2'd0,
        CFG_COUNT = 2'd1
    } t_cfg_idx;

endpackage

[design/dcd_ram.sv]
// ----------------------------------------------------------------------------
// dcd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/dependency_count_task_dispatcher_core.sv]
// ----------------------------------------------------------------------------
// dependency_count_task_dispatcher_core
// Dependency-counting task dispatcher: successor rows, pending counts and the
// ready queue live in RAMs, walked by a read-modify-write sequencer.
//
// channel  direction  handshake                 payload
// in       input      i_valid / o_stall         i_cmd, i_task_req, i_predecessor
// out      output     o_valid / i_stall         o_dispatched_task, o_status, o_last
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item at a time; a dispatch result runs S_TAIL, S_POP, S_OUT, any other S_TAIL, S_OUT
// edge: S_EDGE_RD, S_EDGE_WR, then results; start: pending scan of cnt entries, then results
// completion: S_CMP_RD, S_CMP_ROW, then the pending scan (one entry per cycle), then results
// other items run only the result tail; S_OUT holds each result while i_stall is high
// synchronous active-low reset, valid bits make both graph RAMs read as zero
// o_stall is high from acceptance until the last result of the item is taken
// ----------------------------------------------------------------------------
module dependency_count_task_dispatcher_core #(
    parameter int MAX_TASKS = dcd_pkg::MAX_TASKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dcd_pkg::CMD_W-1:0]     i_cmd,
    input  logic [dcd_pkg::TASK_W-1:0]    i_task_req,
    input  logic [dcd_pkg::TASK_W-1:0]    i_predecessor,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dcd_pkg::TASK_W-1:0]    o_dispatched_task,
    output logic [dcd_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dcd_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int TW   = $clog2(MAX_TASKS);
    localparam int CW   = $clog2(MAX_TASKS + 1);
    localparam int CMPW = (CW > dcd_pkg::CFG_W) ? CW : dcd_pkg::CFG_W;
    localparam int TXW  = (TW > dcd_pkg::TASK_W) ? TW : dcd_pkg::TASK_W;

    localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_TASKS);
    localparam logic [CMPW-1:0] LIM_C = CMPW'(dcd_pkg::LIMIT_MAX);
    localparam logic [CMPW-1:0] ONE_C = CMPW'(1);
    localparam logic [TW-1:0]   LAST_SLOT = TW'(MAX_TASKS - 1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_EDGE_RD = 9'b000000010,
        S_EDGE_WR = 9'b000000100,
        S_CMP_RD  = 9'b000001000,
        S_CMP_ROW = 9'b000010000,
        S_SCAN    = 9'b000100000,
        S_TAIL    = 9'b001000000,
        S_POP     = 9'b010000000,
        S_OUT     = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [dcd_pkg::CFG_W-1:0] r_limit, n_limit;
    logic [dcd_pkg::CFG_W-1:0] r_task_count, n_task_count;

    logic [MAX_TASKS-1:0] r_succ_vld, n_succ_vld;
    logic [MAX_TASKS-1:0] r_pend_vld, n_pend_vld;
    logic [MAX_TASKS-1:0] r_running, n_running;
    logic [MAX_TASKS-1:0] r_row, n_row;

    logic [TW-1:0] r_tr, n_tr;
    logic [TW-1:0] r_pr, n_pr;
    logic [TW-1:0] r_head, n_head;
    logic [TW-1:0] r_chk_idx, n_chk_idx;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_active, n_active;
    logic [CW-1:0] r_completed, n_completed;

    logic r_chk_vld, n_chk_vld;
    logic r_mode_cmp, n_mode_cmp;
    logic r_started, n_started;
    logic r_succ_ok, r_pend_ok;

    logic                         r_out_vld, n_out_vld;
    logic [dcd_pkg::TASK_W-1:0]   r_out_task, n_out_task;
    logic [dcd_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic                         r_out_last, n_out_last;

    // ram ports
    logic                 succ_we, pend_we, fifo_we;
    logic [TW-1:0]        succ_waddr, succ_raddr, pend_waddr, pend_raddr;
    logic [TW-1:0]        fifo_waddr, fifo_raddr;
    logic [MAX_TASKS-1:0] succ_wdata, succ_rdata, succ_q;
    logic [CW-1:0]        pend_wdata, pend_rdata, pend_q;
    logic [TW-1:0]        fifo_wdata, fifo_rdata;

    logic [CMPW-1:0] tc_w, cnt_w, lim_raw, lim_w, tr_w, pr_w;
    logic [TXW-1:0]  tr_x, pr_x, pop_x;
    logic [TW-1:0]   tr_i, pr_i;
    logic [CW:0]     push_sum, push_wrap;
    logic            more, done, fifo_full, push;
    logic [MAX_TASKS-1:0] edge_bit;

    dcd_ram #(.WIDTH(MAX_TASKS), .DEPTH(MAX_TASKS)) u_succ_ram (
        .i_clk   (i_clk),
        .i_we    (succ_we),
        .i_waddr (succ_waddr),
        .i_wdata (succ_wdata),
        .i_raddr (succ_raddr),
        .o_rdata (succ_rdata)
    );

    dcd_ram #(.WIDTH(CW), .DEPTH(MAX_TASKS)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (pend_raddr),
        .o_rdata (pend_rdata)
    );

    dcd_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (fifo_waddr),
        .i_wdata (fifo_wdata),
        .i_raddr (fifo_raddr),
        .o_rdata (fifo_rdata)
    );

    assign tc_w    = CMPW'(r_task_count);
    assign cnt_w   = (tc_w > MAX_C) ? MAX_C : tc_w;
    assign lim_raw = CMPW'(r_limit);
    assign lim_w   = (lim_raw == '0) ? ONE_C : ((lim_raw > LIM_C) ? LIM_C : lim_raw);
    assign tr_w    = CMPW'(i_task_req);
    assign pr_w    = CMPW'(i_predecessor);
    assign tr_x    = TXW'(i_task_req);
    assign pr_x    = TXW'(i_predecessor);
    assign tr_i    = tr_x[TW-1:0];
    assign pr_i    = pr_x[TW-1:0];
    assign pop_x   = TXW'(fifo_rdata);

    // entries never written read as zero
    assign succ_q = r_succ_ok ? succ_rdata : '0;
    assign pend_q = r_pend_ok ? pend_rdata : '0;

    assign more = r_started && (r_used != '0) && (CMPW'(r_active) < lim_w);
    assign done = r_started && (CMPW'(r_completed) >= cnt_w);

    assign push_sum  = (CW + 1)'(r_head) + (CW + 1)'(r_used);
    assign push_wrap = (push_sum >= (CW + 1)'(MAX_TASKS)) ?
                       (push_sum - (CW + 1)'(MAX_TASKS)) : push_sum;
    assign fifo_full = (CMPW'(r_used) >= MAX_C);
    assign edge_bit  = {{(MAX_TASKS - 1){1'b0}}, 1'b1} << r_tr;

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_vld;
    assign o_dispatched_task = r_out_task;
    assign o_status          = r_out_status;
    assign o_last            = r_out_last;
    assign o_cfg_ready       = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_limit      = r_limit;
        n_task_count = r_task_count;
        n_succ_vld   = r_succ_vld;
        n_pend_vld   = r_pend_vld;
        n_running    = r_running;
        n_row        = r_row;
        n_tr         = r_tr;
        n_pr         = r_pr;
        n_head       = r_head;
        n_chk_idx    = r_chk_idx;
        n_idx        = r_idx;
        n_used       = r_used;
        n_active     = r_active;
        n_completed  = r_completed;
        n_chk_vld    = r_chk_vld;
        n_mode_cmp   = r_mode_cmp;
        n_started    = r_started;
        n_out_vld    = r_out_vld;
        n_out_task   = r_out_task;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        succ_we      = 1'b0;
        succ_waddr   = r_pr;
        succ_wdata   = succ_q | edge_bit;
        succ_raddr   = r_tr;
        pend_we      = 1'b0;
        pend_waddr   = r_tr;
        pend_wdata   = pend_q + 1'b1;
        pend_raddr   = r_tr;
        fifo_we      = 1'b0;
        fifo_waddr   = push_wrap[TW-1:0];
        fifo_wdata   = r_chk_idx;
        fifo_raddr   = r_head;
        push         = 1'b0;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dcd_pkg::CFG_LIMIT: n_limit      = i_cfg_data;
                dcd_pkg::CFG_COUNT: n_task_count = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_tr = tr_i;
                    n_pr = pr_i;
                    unique case (i_cmd)
                        dcd_pkg::CMD_EDGE: begin
                            if (!r_started && (tr_w < cnt_w) && (pr_w < cnt_w)) begin
                                n_state = S_EDGE_RD;
                            end else begin
                                n_state = S_TAIL;
                            end
                        end
                        dcd_pkg::CMD_START: begin
                            if (!r_started) begin
                                n_started  = 1'b1;
                                n_mode_cmp = 1'b0;
                                n_idx      = '0;
                                n_chk_vld  = 1'b0;
                                n_state    = S_SCAN;
                            end else begin
                                n_state = S_TAIL;
                            end
                        end
                        dcd_pkg::CMD_COMPLETE: begin
                            if (r_started && (tr_w < cnt_w) && r_running[tr_i]) begin
                                n_running[tr_i] = 1'b0;
                                if (r_active != '0) begin
                                    n_active = r_active - 1'b1;
                                end
                                n_completed = r_completed + 1'b1;
                                n_mode_cmp  = 1'b1;
                                n_state     = S_CMP_RD;
                            end else begin
                                n_state = S_TAIL;
                            end
                        end
                        default: begin
                            n_state = S_TAIL;
                        end
                    endcase
                end
            end
            S_EDGE_RD: begin
                succ_raddr = r_pr;
                pend_raddr = r_tr;
                n_state    = S_EDGE_WR;
            end
            S_EDGE_WR: begin
                // duplicate edge counts once
                if (!succ_q[r_tr]) begin
                    succ_we          = 1'b1;
                    pend_we          = 1'b1;
                    n_succ_vld[r_pr] = 1'b1;
                    n_pend_vld[r_tr] = 1'b1;
                end
                n_state = S_TAIL;
            end
            S_CMP_RD: begin
                succ_raddr = r_tr;
                n_state    = S_CMP_ROW;
            end
            S_CMP_ROW: begin
                n_row     = succ_q;
                n_idx     = '0;
                n_chk_vld = 1'b0;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                // read stage
                if (CMPW'(r_idx) < cnt_w) begin
                    pend_raddr = r_idx[TW-1:0];
                    n_chk_vld  = 1'b1;
                    n_chk_idx  = r_idx[TW-1:0];
                    n_idx      = r_idx + 1'b1;
                end else begin
                    n_chk_vld = 1'b0;
                end
                // check and write-back stage
                if (r_chk_vld) begin
                    if (r_mode_cmp) begin
                        if (r_row[r_chk_idx] && (pend_q != '0)) begin
                            pend_we               = 1'b1;
                            pend_waddr            = r_chk_idx;
                            pend_wdata            = pend_q - 1'b1;
                            n_pend_vld[r_chk_idx] = 1'b1;
                            push                  = (pend_q == CW'(1));
                        end
                    end else begin
                        push = (pend_q == '0);
                    end
                end
                if (push && !fifo_full) begin
                    fifo_we = 1'b1;
                    n_used  = r_used + 1'b1;
                end
                if (!r_chk_vld && (CMPW'(r_idx) >= cnt_w)) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (more) begin
                    fifo_raddr = r_head;
                    n_head     = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                    n_used     = r_used - 1'b1;
                    n_active   = r_active + 1'b1;
                    n_state    = S_POP;
                end else begin
                    n_out_vld    = 1'b1;
                    n_out_task   = '0;
                    n_out_status = done ? dcd_pkg::STAT_DONE : dcd_pkg::STAT_NONE;
                    n_out_last   = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_POP: begin
                n_running[fifo_rdata] = 1'b1;
                n_out_vld    = 1'b1;
                n_out_task   = pop_x[dcd_pkg::TASK_W-1:0];
                n_out_status = dcd_pkg::STAT_DISPATCH;
                n_out_last   = !more && !done;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_out_vld = 1'b0;
                    n_state   = r_out_last ? S_IDLE : S_TAIL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_limit      <= dcd_pkg::CFG_W'(1);
            r_task_count <= '0;
            r_succ_vld   <= '0;
            r_pend_vld   <= '0;
            r_running    <= '0;
            r_head       <= '0;
            r_idx        <= '0;
            r_used       <= '0;
            r_active     <= '0;
            r_completed  <= '0;
            r_chk_vld    <= 1'b0;
            r_started    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_limit      <= n_limit;
            r_task_count <= n_task_count;
            r_succ_vld   <= n_succ_vld;
            r_pend_vld   <= n_pend_vld;
            r_running    <= n_running;
            r_head       <= n_head;
            r_idx        <= n_idx;
            r_used       <= n_used;
            r_active     <= n_active;
            r_completed  <= n_completed;
            r_chk_vld    <= n_chk_vld;
            r_started    <= n_started;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row        <= n_row;
        r_tr         <= n_tr;
        r_pr         <= n_pr;
        r_chk_idx    <= n_chk_idx;
        r_mode_cmp   <= n_mode_cmp;
        r_out_task   <= n_out_task;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_succ_ok    <= r_succ_vld[succ_raddr];
        r_pend_ok    <= r_pend_vld[pend_raddr];
    end

`ifndef SYNTHESIS
    a_running_matches_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_running) == int'(r_active)))
        else $error("running mask and active count disagree");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> (r_state == S_IDLE))
        else $error("not idle after final result of an item");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == dcd_pkg::STAT_DONE)) |-> o_last)
        else $error("done result not marked last");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMPW'(r_used) <= MAX_C))
        else $error("ready queue overflow");

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !o_valid)
        else $error("item accepted while result pending");
`endif

endmodule
